// ===== hdl/sbce_pkg.sv =====
// Shared package for the 16-bit execute block: opcodes, widths and the
// front-to-back queue entry. No dependencies.
`default_nettype none
package sbce_pkg;
  localparam int unsigned RegCountDefault = 4;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [4:0] {
    OP_NOP = 5'd0, OP_HALT = 5'd1, OP_ERROR = 5'd2, OP_REGJUMP = 5'd3,
    OP_MOVE = 5'd4, OP_IMM = 5'd5, OP_IMM2 = 5'd6, OP_CALL = 5'd7,
    OP_JUMP = 5'd8, OP_LOAD = 5'd9, OP_STORE = 5'd10, OP_ADD = 5'd11,
    OP_SUB = 5'd12, OP_XOR = 5'd13, OP_AND = 5'd14, OP_OR = 5'd15,
    OP_SHL = 5'd16, OP_SHR = 5'd17, OP_ASR = 5'd18, OP_IFEQ = 5'd19,
    OP_IFNE = 5'd20, OP_IFLT = 5'd21, OP_IFGE = 5'd22, OP_IFULT = 5'd23,
    OP_IFUGE = 5'd24, OP_LDRESP = 5'd25
  } op_t;

  // classified instruction passed from front to back
  typedef struct packed {
    logic [4:0]  op;
    logic        is_ldresp;
    logic        is_known;
    logic        reg_form;
    logic [1:0]  dest_reg;
    logic [1:0]  src_reg;
    logic [12:0] immediate;
    logic [15:0] load_data;
  } instr_t;
endpackage
`default_nettype wire

// ===== hdl/sbce_front.sv =====
// Front end: accepts items, classifies the opcode, and buffers them in a
// short queue toward the execute stage. Depends on sbce_pkg.
`default_nettype none
module sbce_front
  import sbce_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [4:0]  in_op,
  input  wire logic        in_reg_form,
  input  wire logic [1:0]  in_dest_reg,
  input  wire logic [1:0]  in_src_reg,
  input  wire logic [12:0] in_immediate,
  input  wire logic [15:0] in_load_data,
  output logic             q_valid,
  input  wire logic        q_ready,
  output instr_t           q_data
);
  instr_t     mem_r [QueueDepth];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  instr_t     cls;
  logic       push, pop;

  always_comb begin
    cls.op        = in_op;
    cls.is_ldresp = (in_op == OP_LDRESP);
    cls.is_known  = (in_op <= OP_LDRESP) && (in_op != OP_ERROR);
    cls.reg_form  = in_reg_form;
    cls.dest_reg  = in_dest_reg;
    cls.src_reg   = in_src_reg;
    cls.immediate = in_immediate;
    cls.load_data = in_load_data;
  end

  assign in_ready = (cnt_r != 2'(QueueDepth));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_data   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(QueueDepth)) else $error("queue overflow");
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'(QueueDepth)) |-> !in_ready) else $error("full but ready");
  a_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 || cnt_r == 2'(QueueDepth)) |-> (wp_r == rp_r))
    else $error("pointer mismatch");
endmodule
`default_nettype wire

// ===== hdl/sbce_back.sv =====
// Back end: architectural state; executes one instruction per cycle unless
// a held result stalls; results in an output register. Depends on sbce_pkg.
`default_nettype none
module sbce_back
  import sbce_pkg::*;
#(
  parameter int unsigned REG_COUNT = RegCountDefault
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   q_valid,
  output logic        q_ready,
  input  instr_t      q_data,
  output logic        out_valid,
  input  wire logic   out_ready,
  output logic [15:0] out_next_pc,
  output logic        out_executed,
  output logic        out_bus_valid,
  output logic        out_bus_write,
  output logic [15:0] out_bus_address,
  output logic [15:0] out_bus_write_data,
  output logic        out_halted,
  output logic        out_errored
);
  logic [15:0] rf_r [REG_COUNT];
  logic [15:0] pc_r, pfx_r;
  logic        pfxv_r, skip_r, skip2_r, ldp_r, halt_r, err_r;
  logic [1:0]  ldt_r;
  logic        ov_r;

  logic [15:0] pc_nxt, pfx_nxt, a, b, rs_val, immop, offop, wval, ba, bd;
  logic        pfxv_nxt, skip_nxt, skip2_nxt, ldp_nxt, halt_nxt, err_nxt;
  logic [1:0]  ldt_nxt, widx;
  logic        we, exe, bv, bw, fail, adv, keep;
  logic        fire;

  function automatic logic [15:0] rd_reg(input logic [1:0] idx,
                                         input logic [15:0] v);
    return (32'(idx) < REG_COUNT) ? v : 16'd0;
  endfunction

  assign q_ready = !ov_r || out_ready;
  assign fire    = q_valid && q_ready;

  always_comb begin
    a      = 16'd0;
    rs_val = 16'd0;
    for (int i = 0; i < REG_COUNT; i++) begin
      if (32'(q_data.dest_reg) == 32'(i)) a = rf_r[i];
      if (32'(q_data.src_reg) == 32'(i)) rs_val = rf_r[i];
    end
    a      = rd_reg(q_data.dest_reg, a);
    rs_val = rd_reg(q_data.src_reg, rs_val);
    if (pfxv_r) immop = pfx_r | {12'd0, q_data.immediate[3:0]};
    else immop = {{3{q_data.immediate[12]}}, q_data.immediate};
    offop = pfxv_r ? immop : {12'd0, q_data.immediate[3:0]};
    b = q_data.reg_form ? rs_val : immop;

    pc_nxt = pc_r; pfx_nxt = pfx_r; pfxv_nxt = pfxv_r;
    skip_nxt = skip_r; skip2_nxt = skip2_r; ldp_nxt = ldp_r; ldt_nxt = ldt_r;
    halt_nxt = halt_r; err_nxt = err_r;
    we = 1'b0; widx = q_data.dest_reg; wval = b;
    exe = 1'b0; bv = 1'b0; bw = 1'b0; ba = 16'd0; bd = 16'd0;
    fail = 1'b0; adv = 1'b1; keep = 1'b0;

    if (q_data.is_ldresp) begin
      if (ldp_r) begin
        we = 1'b1; widx = ldt_r; wval = q_data.load_data;
        ldp_nxt = 1'b0; exe = 1'b1;
      end
    end else if (halt_r || err_r) begin
      // stopped: ignore
    end else if (skip_r) begin
      pc_nxt = pc_r + 16'd1;
      if (skip2_r) begin
        skip2_nxt = 1'b0; skip_nxt = 1'b0;
      end else if (q_data.op == OP_IMM) begin
        skip2_nxt = 1'b1;
      end else begin
        skip_nxt = 1'b0;
      end
    end else begin
      exe = 1'b1;
      if (!q_data.is_known) begin
        err_nxt = 1'b1; adv = 1'b0;
      end else begin
        unique case (q_data.op)
          OP_HALT:    begin halt_nxt = 1'b1; adv = 1'b0; end
          OP_REGJUMP: pc_nxt = a;
          OP_MOVE:    we = 1'b1;
          OP_IMM, OP_IMM2: begin pfx_nxt = {b[11:0], 4'd0}; keep = 1'b1; end
          OP_CALL, OP_JUMP: begin
            // call links through r0 before the jump
            if (q_data.op == OP_CALL) begin
              we = 1'b1; widx = 2'd0; wval = pc_r;
            end
            pc_nxt = q_data.reg_form ? rs_val : pc_r + immop;
            if (q_data.op == OP_CALL && q_data.reg_form && q_data.src_reg == 2'd0)
              pc_nxt = pc_r;
          end
          OP_LOAD, OP_STORE: begin
            bv = 1'b1; ba = rs_val + offop;
            if (q_data.op == OP_STORE) begin
              bw = 1'b1; bd = a;
            end else begin
              ldp_nxt = 1'b1; ldt_nxt = q_data.dest_reg;
            end
          end
          OP_ADD: begin we = 1'b1; wval = a + b; end
          OP_SUB: begin we = 1'b1; wval = a - b; end
          OP_XOR: begin we = 1'b1; wval = a ^ b; end
          OP_AND: begin we = 1'b1; wval = a & b; end
          OP_OR:  begin we = 1'b1; wval = a | b; end
          OP_SHL: begin we = 1'b1; wval = a << b[3:0]; end
          OP_SHR: begin we = 1'b1; wval = a >> b[3:0]; end
          OP_ASR: begin we = 1'b1; wval = 16'($signed(a) >>> b[3:0]); end
          OP_IFEQ:  fail = (a != b);
          OP_IFNE:  fail = (a == b);
          OP_IFLT:  fail = !($signed(a) < $signed(b));
          OP_IFGE:  fail = ($signed(a) < $signed(b));
          OP_IFULT: fail = (a >= b);
          OP_IFUGE: fail = (a < b);
          default: ;
        endcase
      end
      if (adv) begin
        if (keep) pfxv_nxt = 1'b1;
        else begin pfx_nxt = 16'd0; pfxv_nxt = 1'b0; end
        pc_nxt = pc_nxt + 16'd1;
        if (fail) begin skip_nxt = 1'b1; skip2_nxt = 1'b0; end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REG_COUNT; i++) rf_r[i] <= 16'd0;
      pc_r <= 16'd0; pfx_r <= 16'd0; pfxv_r <= 1'b0; skip_r <= 1'b0;
      skip2_r <= 1'b0; ldp_r <= 1'b0; ldt_r <= 2'd0; halt_r <= 1'b0;
      err_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      if (fire) begin
        for (int i = 0; i < REG_COUNT; i++)
          if (we && 32'(widx) == 32'(i)) rf_r[i] <= wval;
        pc_r <= pc_nxt; pfx_r <= pfx_nxt; pfxv_r <= pfxv_nxt;
        skip_r <= skip_nxt; skip2_r <= skip2_nxt; ldp_r <= ldp_nxt;
        ldt_r <= ldt_nxt; halt_r <= halt_nxt; err_r <= err_nxt;
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_next_pc <= pc_nxt; out_executed <= exe; out_bus_valid <= bv;
      out_bus_write <= bw; out_bus_address <= ba; out_bus_write_data <= bd;
      out_halted <= halt_nxt; out_errored <= err_nxt;
    end
  end

  assign out_valid = ov_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ready) |-> !q_ready) else $error("overwrote result");
  a_skip2: assert property (@(posedge clk) disable iff (!rst_n)
    skip2_r |-> skip_r) else $error("second skip without skip");
  a_stop: assert property (@(posedge clk) disable iff (!rst_n)
    $past(halt_r) |-> halt_r) else $error("halt cleared");
endmodule
`default_nettype wire

// ===== hdl/sixteen_bit_cpu_execute.sv =====
// An accepted item is written into the queue, then executed into the output
// register. Throughput: one item per cycle while out_ready does not stall.
// Synchronous active-low reset clears registers, out_valid, queue pointers.
// Top level: front queue plus back executor. Depends on sbce_pkg.
`default_nettype none
module sixteen_bit_cpu_execute
  import sbce_pkg::*;
#(
  parameter int unsigned REG_COUNT = RegCountDefault
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [4:0]  in_op,
  input  wire logic        in_reg_form,
  input  wire logic [1:0]  in_dest_reg,
  input  wire logic [1:0]  in_src_reg,
  input  wire logic [12:0] in_immediate,
  input  wire logic [15:0] in_load_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_next_pc,
  output logic             out_executed,
  output logic             out_bus_valid,
  output logic             out_bus_write,
  output logic [15:0]      out_bus_address,
  output logic [15:0]      out_bus_write_data,
  output logic             out_halted,
  output logic             out_errored
);
  logic   q_valid, q_ready;
  instr_t q_data;

  sbce_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_op, .in_reg_form, .in_dest_reg,
    .in_src_reg, .in_immediate, .in_load_data, .q_valid, .q_ready, .q_data
  );

  sbce_back #(.REG_COUNT(REG_COUNT)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_data, .out_valid, .out_ready,
    .out_next_pc, .out_executed, .out_bus_valid, .out_bus_write,
    .out_bus_address, .out_bus_write_data, .out_halted, .out_errored
  );
endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// Testbench for sixteen_bit_cpu_execute: random and directed instruction items
// are checked against a behavioral predictor in a scoreboard class.
// Depends on sbce_pkg and the RTL of the execute block.
`default_nettype none
module tb;
  import sbce_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [4:0] OpUnknownLo = 5'd26;
  localparam logic [4:0] OpUnknownHi = 5'd31;
  localparam int HoldCycles = 80;
  localparam int DrainCycles = 12;

  typedef struct {
    logic [15:0] next_pc;
    logic        executed;
    logic        bus_valid;
    logic        bus_write;
    logic [15:0] bus_address;
    logic [15:0] bus_write_data;
    logic        halted;
    logic        errored;
  } exec_result_t;

  class execute_scoreboard;
    logic [15:0] regs[4];
    logic [15:0] pc, pfx_value;
    bit pfx_valid, skip_pending, skip_second, load_pending, halted, errored;
    logic [1:0] load_target;
    exec_result_t pending_results[$];
    int fails;

    function new();
      foreach (regs[i]) regs[i] = '0;
      pc = '0;
      pfx_value = '0;
      pfx_valid = 0;
      skip_pending = 0;
      skip_second = 0;
      load_pending = 0;
      halted = 0;
      errored = 0;
      load_target = '0;
      fails = 0;
    endfunction

    function logic [15:0] imm_value(logic [12:0] imm);
      if (pfx_valid) return pfx_value | {12'd0, imm[3:0]};
      return {{3{imm[12]}}, imm};
    endfunction

    function logic [15:0] offset_value(logic [12:0] imm);
      if (pfx_valid) return pfx_value | {12'd0, imm[3:0]};
      return {12'd0, imm[3:0]};
    endfunction

    function void note_item(logic [4:0] op, logic rf, logic [1:0] rd, logic [1:0] rs,
                            logic [12:0] imm, logic [15:0] ld);
      exec_result_t r;
      logic [15:0] a, b;
      bit keep_pfx, fail, advance;
      r = '{default: '0};
      if (op == OP_LDRESP) begin
        if (load_pending) begin
          regs[load_target] = ld;
          load_pending = 0;
          r.executed = 1;
        end
      end else if (halted || errored) begin
        // stopped: instruction ignored
      end else if (skip_pending) begin
        pc = pc + 16'd1;
        if (skip_second) begin
          skip_second = 0;
          skip_pending = 0;
        end else if (op == OP_IMM) begin
          skip_second = 1;
        end else begin
          skip_pending = 0;
        end
      end else begin
        a = regs[rd];
        b = rf ? regs[rs] : imm_value(imm);
        keep_pfx = 0;
        fail = 0;
        advance = 1;
        r.executed = 1;
        case (op)
          OP_NOP: ;
          OP_HALT: begin
            halted = 1;
            advance = 0;
          end
          OP_REGJUMP: pc = a;
          OP_MOVE: regs[rd] = b;
          OP_IMM, OP_IMM2: begin
            pfx_value = b << 4;
            keep_pfx = 1;
          end
          OP_CALL, OP_JUMP: begin
            if (op == OP_CALL) regs[0] = pc;
            // call writes r0 before the operand is read
            pc = rf ? regs[rs] : pc + imm_value(imm);
          end
          OP_LOAD, OP_STORE: begin
            r.bus_valid = 1;
            r.bus_address = regs[rs] + offset_value(imm);
            if (op == OP_STORE) begin
              r.bus_write = 1;
              r.bus_write_data = a;
            end else begin
              load_pending = 1;
              load_target = rd;
            end
          end
          OP_ADD: regs[rd] = a + b;
          OP_SUB: regs[rd] = a - b;
          OP_XOR: regs[rd] = a ^ b;
          OP_AND: regs[rd] = a & b;
          OP_OR: regs[rd] = a | b;
          OP_SHL: regs[rd] = a << b[3:0];
          OP_SHR: regs[rd] = a >> b[3:0];
          OP_ASR: regs[rd] = $signed(a) >>> b[3:0];
          OP_IFEQ: fail = (a != b);
          OP_IFNE: fail = (a == b);
          OP_IFLT: fail = !($signed(a) < $signed(b));
          OP_IFGE: fail = ($signed(a) < $signed(b));
          OP_IFULT: fail = (a >= b);
          OP_IFUGE: fail = (a < b);
          default: begin
            errored = 1;
            advance = 0;
          end
        endcase
        if (advance) begin
          if (!keep_pfx) begin
            pfx_value = '0;
            pfx_valid = 0;
          end else begin
            pfx_valid = 1;
          end
          pc = pc + 16'd1;
          if (fail) begin
            skip_pending = 1;
            skip_second = 0;
          end
        end
      end
      r.next_pc = pc;
      r.halted = halted;
      r.errored = errored;
      pending_results.push_back(r);
    endfunction

    function void cmp(string field, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %h, got %h", field, want, got);
        fails++;
      end
    endfunction

    function void check_result(exec_result_t got);
      exec_result_t want;
      if (pending_results.size() == 0) begin
        $error("result with no item outstanding");
        fails++;
        return;
      end
      want = pending_results.pop_front();
      cmp("next_pc", want.next_pc, got.next_pc);
      cmp("executed", 16'(want.executed), 16'(got.executed));
      cmp("bus_valid", 16'(want.bus_valid), 16'(got.bus_valid));
      cmp("bus_write", 16'(want.bus_write), 16'(got.bus_write));
      cmp("bus_address", want.bus_address, got.bus_address);
      cmp("bus_write_data", want.bus_write_data, got.bus_write_data);
      cmp("halted", 16'(want.halted), 16'(got.halted));
      cmp("errored", 16'(want.errored), 16'(got.errored));
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [4:0] in_op = '0;
  logic in_reg_form = 0;
  logic [1:0] in_dest_reg = '0;
  logic [1:0] in_src_reg = '0;
  logic [12:0] in_immediate = '0;
  logic [15:0] in_load_data = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [15:0] out_next_pc, out_bus_address, out_bus_write_data;
  logic out_executed, out_bus_valid, out_bus_write, out_halted, out_errored;

  execute_scoreboard sb = new();
  bit calm = 0;
  bit hold_go = 0;

  sixteen_bit_cpu_execute dut (.*);

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        sb.check_result('{out_next_pc, out_executed, out_bus_valid, out_bus_write,
                          out_bus_address, out_bus_write_data, out_halted, out_errored});
      if (in_valid && in_ready)
        sb.note_item(in_op, in_reg_form, in_dest_reg, in_src_reg, in_immediate,
                     in_load_data);
    end
  end

  // result side: random stalls plus one long hold-off on request
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_go) begin
        hold_go = 0;
        out_ready <= 0;
        repeat (HoldCycles) @(negedge clk);
      end
      out_ready <= calm || ($urandom_range(99) >= 19);
    end
  end

  task automatic send(logic [4:0] op, logic rf, logic [1:0] rd, logic [1:0] rs,
                      logic [12:0] imm, logic [15:0] ld);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 19) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_op <= op;
    in_reg_form <= rf;
    in_dest_reg <= rd;
    in_src_reg <= rs;
    in_immediate <= imm;
    in_load_data <= ld;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random();
    int unsigned pick;
    logic [4:0] op;
    pick = $urandom_range(99);
    if (pick < 10) op = OP_LDRESP;
    else if (pick < 18) op = OP_LOAD;
    else if (pick < 22) op = OP_IMM;
    else if (pick < 25) begin
      // a nop soaks up any pending skip, so the condition always executes and
      // fails, and the stopping op after it is skipped
      send(OP_NOP, 0, 2'd0, 2'd0, 13'd0, 16'd0);
      send(OP_IFNE, 1, 2'(pick), 2'(pick), 13'($urandom), 16'($urandom));
      op = ($urandom_range(2) == 0) ? OP_HALT :
           ($urandom_range(1) == 0) ? OP_ERROR : 5'($urandom_range(OpUnknownLo, OpUnknownHi));
    end else begin
      do op = 5'($urandom_range(0, OP_IFUGE)); while (op == OP_HALT || op == OP_ERROR);
    end
    send(op, 1'($urandom), 2'($urandom), 2'($urandom), 13'($urandom), 16'($urandom));
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    // directed: operand extremes, prefixes, every op, skip cases
    send(OP_MOVE, 0, 0, 0, 13'h0fff, 16'h0);
    send(OP_MOVE, 0, 1, 0, 13'h1000, 16'h0);
    send(OP_IMM, 0, 0, 0, 13'h1fff, 16'h0);
    send(OP_ADD, 0, 2, 0, 13'h000f, 16'h0);
    send(OP_IMM2, 0, 0, 0, 13'h0abc, 16'h0);
    send(OP_SUB, 1, 2, 1, 13'h0, 16'h0);
    send(OP_XOR, 0, 3, 0, 13'h1555, 16'h0);
    send(OP_AND, 1, 3, 1, 13'h0, 16'h0);
    send(OP_OR, 1, 3, 0, 13'h0, 16'h0);
    send(OP_SHL, 0, 0, 0, 13'h000f, 16'h0);
    send(OP_SHR, 0, 1, 0, 13'h0004, 16'h0);
    send(OP_ASR, 0, 1, 0, 13'h0003, 16'h0);
    send(OP_IFNE, 1, 0, 0, 13'h0, 16'h0);
    send(OP_HALT, 0, 0, 0, 13'h0, 16'h0);
    send(OP_IFNE, 1, 1, 1, 13'h0, 16'h0);
    send(OP_IMM, 0, 0, 0, 13'h1234, 16'h0);   // skipped IMM also skips the next
    send(OP_ERROR, 0, 0, 0, 13'h0, 16'h0);
    send(OP_IFULT, 1, 0, 0, 13'h0, 16'h0);
    send(OpUnknownHi, 0, 0, 0, 13'h0, 16'h0);
    send(OP_LOAD, 0, 2, 1, 13'h1fff, 16'h0);
    send(OP_LDRESP, 0, 0, 0, 13'h0, 16'hffff);
    send(OP_LDRESP, 0, 0, 0, 13'h0, 16'h1234);  // nothing pending
    send(OP_STORE, 0, 2, 3, 13'h0005, 16'h0);
    send(OP_CALL, 0, 0, 0, 13'h1ff0, 16'h0);
    send(OP_CALL, 1, 0, 2, 13'h0, 16'h0);
    send(OP_JUMP, 0, 0, 0, 13'h0010, 16'h0);
    send(OP_JUMP, 1, 0, 3, 13'h0, 16'h0);
    send(OP_REGJUMP, 0, 1, 0, 13'h0, 16'h0);
    send(OP_IFLT, 0, 1, 0, 13'h0000, 16'h0);
    send(OP_IFGE, 0, 1, 0, 13'h0000, 16'h0);
    send(OP_IFEQ, 1, 2, 2, 13'h0, 16'h0);
    send(OP_IFUGE, 0, 0, 0, 13'h1fff, 16'h0);
    send(OP_NOP, 0, 0, 0, 13'h0, 16'h0);
    for (int i = 0; i < 440; i++) begin
      if (i == 100) hold_go = 1;
      if (i == 200) calm = 1;
      if (i == 260) calm = 0;
      if (i == 320) begin
        @(negedge clk);
        in_valid <= 0;
        wait (sb.pending_results.size() == 0);
      end
      send_random();
    end
    // stop the core last: unknown op sets errored; later ops but LDRESP ignored
    send(OP_LOAD, 1, 3, 0, 13'h0, 16'h0);
    send(5'($urandom_range(OpUnknownLo, OpUnknownHi)), 0, 0, 0, 13'h0, 16'h0);
    send(OP_HALT, 0, 0, 0, 13'h0, 16'h0);
    send(OP_ADD, 0, 0, 0, 13'h0001, 16'h0);
    send(OP_LDRESP, 0, 0, 0, 13'h0, 16'hbeef);
    @(negedge clk);
    in_valid <= 0;
    wait (sb.pending_results.size() == 0);
    repeat (DrainCycles) @(posedge clk);
    if (sb.fails == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Some tests failed");
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
hdl/sbce_pkg.sv
hdl/sbce_front.sv
hdl/sbce_back.sv
hdl/sixteen_bit_cpu_execute.sv
dv/tb.sv
